### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the design files.
// Each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg
// Types, codes and rectangle helpers for the damage rectangle tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package drt_pkg;

    localparam int MAX_RECTS_DEF = 8;
    localparam logic [31:0] AREA_WORST = 32'h7FFF_FFFF;

    localparam logic [11:0] SCREEN_W_RST = 12'd240;
    localparam logic [11:0] SCREEN_H_RST = 12'd240;
    localparam logic [19:0] STRIP_RST    = 20'd9600;
    localparam int DIV_STEPS = 20;

    // Action codes of an input item.
    typedef enum logic [2:0] {
        ACT_ADD   = 3'd0,
        ACT_ALL   = 3'd1,
        ACT_BEGIN = 3'd2,
        ACT_NEXT  = 3'd3,
        ACT_END   = 3'd4
    } action_t;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_STRIP  = 2'd2
    } reg_idx_t;

    // One stored rectangle, always clipped to a screen of at most 4095 pixels.
    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [12:0] w;
        logic [12:0] h;
    } rect_t;

    // True when the two rectangles overlap.
    function automatic logic rect_touch(rect_t a, rect_t b);
        logic [13:0] ax2;
        logic [13:0] ay2;
        logic [13:0] bx2;
        logic [13:0] by2;
        ax2 = {2'b00, a.x} + {1'b0, a.w};
        ay2 = {2'b00, a.y} + {1'b0, a.h};
        bx2 = {2'b00, b.x} + {1'b0, b.w};
        by2 = {2'b00, b.y} + {1'b0, b.h};
        return ({2'b00, a.x} < bx2) && ({2'b00, b.x} < ax2) &&
               ({2'b00, a.y} < by2) && ({2'b00, b.y} < ay2);
    endfunction

    // Bounding box of the two rectangles.
    function automatic rect_t rect_join(rect_t a, rect_t b);
        logic [13:0] ax2;
        logic [13:0] ay2;
        logic [13:0] bx2;
        logic [13:0] by2;
        logic [13:0] x2;
        logic [13:0] y2;
        rect_t u;
        ax2 = {2'b00, a.x} + {1'b0, a.w};
        ay2 = {2'b00, a.y} + {1'b0, a.h};
        bx2 = {2'b00, b.x} + {1'b0, b.w};
        by2 = {2'b00, b.y} + {1'b0, b.h};
        x2 = (ax2 > bx2) ? ax2 : bx2;
        y2 = (ay2 > by2) ? ay2 : by2;
        u.x = (a.x < b.x) ? a.x : b.x;
        u.y = (a.y < b.y) ? a.y : b.y;
        u.w = 13'(x2 - {2'b00, u.x});
        u.h = 13'(y2 - {2'b00, u.y});
        return u;
    endfunction

endpackage

`default_nettype wire

### design/damage_rect_tracker_band_slicer.sv
// ----------------------------------------------------------------------------
// damage_rect_tracker_band_slicer
// Bounded damage rectangle list with frame coalescing and band slicing.
// ----------------------------------------------------------------------------
// Each item is worked on alone and the input is stalled until its result is
// in the output register. Add-all, end and ignored items go straight to the
// output register. An add scans for the first overlapping entry and merges
// into it; with none it appends, or, when the list is full, merges into the
// entry of least growth; one shared 13x13 multiplier forms the two areas of
// each entry. Begin walks all entry pairs, and after each merge moves the
// last entry into the hole and restarts the walk. A next band checks for the
// next rectangle with rows left, skipping exhausted ones, then runs a 20-step
// restoring divider for strip / width and a finishing step; with no band left
// it returns none.
`default_nettype none

module damage_rect_tracker_band_slicer #(
    parameter int MAX_RECTS = drt_pkg::MAX_RECTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  action,
    input  wire logic signed [15:0] rect_x,
    input  wire logic signed [15:0] rect_y,
    input  wire logic signed [15:0] rect_w,
    input  wire logic signed [15:0] rect_h,
    // Output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             band_valid,
    output logic      [11:0] band_x,
    output logic      [11:0] band_y,
    output logic      [12:0] band_w,
    output logic      [12:0] band_h,
    output logic             frame_open
);

    localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam int DW = $clog2(drt_pkg::DIV_STEPS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_SCAN, S_COST_A, S_COST_B, S_M_LOAD, S_M_SCAN, S_M_MOVE,
        S_B_CHECK, S_B_DIV, S_B_FIN, S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            open_reg, open_next;
    logic [CW-1:0]   walk_reg, walk_next;
    logic [12:0]     off_reg, off_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [IW-1:0]   best_reg, best_next;
    logic [31:0]     cost_reg, cost_next;
    logic [25:0]     area_reg, area_next;
    drt_pkg::rect_t  hold_reg, hold_next;
    drt_pkg::rect_t  cand_reg, cand_next;
    logic [19:0]     quo_reg, quo_next;
    logic [12:0]     rem_reg, rem_next;
    logic [DW-1:0]   dcnt_reg, dcnt_next;
    logic            res_valid_reg, res_valid_next;
    drt_pkg::rect_t  res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    logic            band_valid_reg, band_valid_next;
    drt_pkg::rect_t  band_reg, band_next;
    logic            fopen_reg, fopen_next;
    logic [11:0]     sw_reg;
    logic [11:0]     sh_reg;
    logic [19:0]     strip_reg;

    drt_pkg::rect_t  rect_table [MAX_RECTS];
    logic [IW-1:0]   rd_addr;
    drt_pkg::rect_t  rd_data;
    logic            tbl_we;
    logic [IW-1:0]   tbl_wa;
    drt_pkg::rect_t  tbl_wd;

    logic [12:0]     mul_a;
    logic [12:0]     mul_b;
    logic [25:0]     mul_p;

    logic            accept;
    logic            cfg_wr;
    logic            clip_ok;
    drt_pkg::rect_t  clip_rect;
    drt_pkg::rect_t  rd_join_cand;
    logic [25:0]     cost_cur;
    logic [13:0]     rem_sh;
    logic [19:0]     rows_q;
    logic [12:0]     rows_left;
    logic [12:0]     rows;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg    <= drt_pkg::SCREEN_W_RST;
            sh_reg    <= drt_pkg::SCREEN_H_RST;
            strip_reg <= drt_pkg::STRIP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                drt_pkg::REG_WIDTH:  sw_reg    <= pwdata[11:0];
                drt_pkg::REG_HEIGHT: sh_reg    <= pwdata[11:0];
                drt_pkg::REG_STRIP:  strip_reg <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            drt_pkg::REG_WIDTH:  prdata = {20'd0, sw_reg};
            drt_pkg::REG_HEIGHT: prdata = {20'd0, sh_reg};
            drt_pkg::REG_STRIP:  prdata = {12'd0, strip_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // Rectangle table, one read and one write address per cycle.
    assign rd_data = rect_table[rd_addr];

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            rect_table[tbl_wa] <= tbl_wd;
        end
    end

    // Clip the incoming rectangle against the screen.
    always_comb
    begin
        logic signed [17:0] x2;
        logic signed [17:0] y2;
        logic signed [17:0] cx;
        logic signed [17:0] cy;
        logic signed [17:0] cw;
        logic signed [17:0] ch;
        x2 = 18'(rect_x) + 18'(rect_w);
        y2 = 18'(rect_y) + 18'(rect_h);
        if (x2 > $signed({6'd0, sw_reg}))
        begin
            x2 = $signed({6'd0, sw_reg});
        end
        if (y2 > $signed({6'd0, sh_reg}))
        begin
            y2 = $signed({6'd0, sh_reg});
        end
        cx = (rect_x < 0) ? 18'sd0 : 18'(rect_x);
        cy = (rect_y < 0) ? 18'sd0 : 18'(rect_y);
        cw = x2 - cx;
        ch = y2 - cy;
        clip_ok = (rect_w > 0) && (rect_h > 0) && (cw > 0) && (ch > 0);
        clip_rect.x = cx[11:0];
        clip_rect.y = cy[11:0];
        clip_rect.w = cw[12:0];
        clip_rect.h = ch[12:0];
    end

    // Shared multiplier for the area comparison.
    assign mul_p = 26'(mul_a) * 26'(mul_b);

    assign rd_join_cand = drt_pkg::rect_join(rd_data, cand_reg);
    assign cost_cur     = area_reg - mul_p;

    // Divider step and band row count.
    assign rem_sh    = {rem_reg, quo_reg[19]};
    assign rows_q    = (quo_reg == 20'd0) ? 20'd1 : quo_reg;
    assign rows_left = rd_data.h - off_reg;
    assign rows      = (rows_q > {7'd0, rows_left}) ? rows_left : rows_q[12:0];

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        open_next       = open_reg;
        walk_next       = walk_reg;
        off_next        = off_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        best_next       = best_reg;
        cost_next       = cost_reg;
        area_next       = area_reg;
        hold_next       = hold_reg;
        cand_next       = cand_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        dcnt_next       = dcnt_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && out_stall;
        band_valid_next = band_valid_reg;
        band_next       = band_reg;
        fopen_next      = fopen_reg;
        rd_addr         = i_reg[IW-1:0];
        tbl_we          = 1'b0;
        tbl_wa          = i_reg[IW-1:0];
        tbl_wd          = rd_data;
        mul_a           = rd_join_cand.w;
        mul_b           = rd_join_cand.h;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_valid_next = 1'b0;
                    res_next       = '0;
                    i_next         = '0;
                    state_next     = S_DONE;
                    case (action)
                        drt_pkg::ACT_ADD:
                        begin
                            if (!open_reg && clip_ok)
                            begin
                                cand_next  = clip_rect;
                                state_next = S_ADD_SCAN;
                            end
                        end
                        drt_pkg::ACT_ALL:
                        begin
                            if (!open_reg)
                            begin
                                tbl_we   = 1'b1;
                                tbl_wa   = '0;
                                tbl_wd   = {12'd0, 12'd0, 1'b0, sw_reg, 1'b0, sh_reg};
                                cnt_next = CW'(1);
                            end
                        end
                        drt_pkg::ACT_BEGIN:
                        begin
                            if (!open_reg)
                            begin
                                state_next = S_M_LOAD;
                            end
                        end
                        drt_pkg::ACT_NEXT:
                        begin
                            if (open_reg)
                            begin
                                state_next = S_B_CHECK;
                            end
                        end
                        drt_pkg::ACT_END:
                        begin
                            if (open_reg)
                            begin
                                cnt_next  = '0;
                                open_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Look for the first entry that overlaps the new rectangle.
            S_ADD_SCAN:
            begin
                if (i_reg == cnt_reg)
                begin
                    if (cnt_reg < CW'(MAX_RECTS))
                    begin
                        tbl_we     = 1'b1;
                        tbl_wa     = cnt_reg[IW-1:0];
                        tbl_wd     = cand_reg;
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = '0;
                        best_next  = '0;
                        cost_next  = drt_pkg::AREA_WORST;
                        state_next = S_COST_A;
                    end
                end
                else if (drt_pkg::rect_touch(rd_data, cand_reg))
                begin
                    tbl_we     = 1'b1;
                    tbl_wd     = rd_join_cand;
                    state_next = S_DONE;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                end
            end

            // Union area of entry i, or the final merge into the best entry.
            S_COST_A:
            begin
                if (i_reg == CW'(MAX_RECTS))
                begin
                    rd_addr    = best_reg;
                    tbl_we     = 1'b1;
                    tbl_wa     = best_reg;
                    tbl_wd     = rd_join_cand;
                    state_next = S_DONE;
                end
                else
                begin
                    area_next  = mul_p;
                    state_next = S_COST_B;
                end
            end

            // Growth of entry i; keep the first smallest.
            S_COST_B:
            begin
                mul_a = rd_data.w;
                mul_b = rd_data.h;
                if ({6'd0, cost_cur} < cost_reg)
                begin
                    cost_next = {6'd0, cost_cur};
                    best_next = i_reg[IW-1:0];
                end
                i_next     = i_reg + CW'(1);
                state_next = S_COST_A;
            end

            // Coalescing: hold entry i and scan the later ones.
            S_M_LOAD:
            begin
                if ({1'b0, i_reg} + (CW+1)'(1) >= {1'b0, cnt_reg})
                begin
                    walk_next  = '0;
                    off_next   = '0;
                    open_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    hold_next  = rd_data;
                    j_next     = i_reg + CW'(1);
                    state_next = S_M_SCAN;
                end
            end

            S_M_SCAN:
            begin
                rd_addr = j_reg[IW-1:0];
                if (drt_pkg::rect_touch(hold_reg, rd_data))
                begin
                    tbl_we     = 1'b1;
                    tbl_wd     = drt_pkg::rect_join(hold_reg, rd_data);
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_M_MOVE;
                end
                else if ({1'b0, j_reg} + (CW+1)'(1) >= {1'b0, cnt_reg})
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_M_LOAD;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end

            // Move the last entry into the hole and restart the scan.
            S_M_MOVE:
            begin
                rd_addr    = cnt_reg[IW-1:0];
                tbl_we     = 1'b1;
                tbl_wa     = j_reg[IW-1:0];
                tbl_wd     = rd_data;
                i_next     = '0;
                state_next = S_M_LOAD;
            end

            // Find the next rectangle with rows left.
            S_B_CHECK:
            begin
                rd_addr = walk_reg[IW-1:0];
                if (walk_reg >= cnt_reg)
                begin
                    state_next = S_DONE;
                end
                else if (off_reg >= rd_data.h)
                begin
                    walk_next = walk_reg + CW'(1);
                    off_next  = '0;
                end
                else
                begin
                    quo_next   = strip_reg;
                    rem_next   = '0;
                    dcnt_next  = DW'(drt_pkg::DIV_STEPS);
                    state_next = S_B_DIV;
                end
            end

            // One quotient bit per cycle.
            S_B_DIV:
            begin
                rd_addr = walk_reg[IW-1:0];
                if (rem_sh >= {1'b0, rd_data.w})
                begin
                    rem_next = 13'(rem_sh - {1'b0, rd_data.w});
                    quo_next = {quo_reg[18:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[12:0];
                    quo_next = {quo_reg[18:0], 1'b0};
                end
                dcnt_next = dcnt_reg - DW'(1);
                if (dcnt_reg == DW'(1))
                begin
                    state_next = S_B_FIN;
                end
            end

            S_B_FIN:
            begin
                rd_addr        = walk_reg[IW-1:0];
                res_valid_next = 1'b1;
                res_next.x     = rd_data.x;
                res_next.y     = 12'({1'b0, rd_data.y} + off_reg);
                res_next.w     = rd_data.w;
                res_next.h     = rows;
                off_next       = off_reg + rows;
                state_next     = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    band_valid_next = res_valid_reg;
                    band_next       = res_reg;
                    fopen_next      = open_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            open_reg      <= 1'b0;
            walk_reg      <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            open_reg      <= open_next;
            walk_reg      <= walk_next;
            off_reg       <= off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        best_reg       <= best_next;
        cost_reg       <= cost_next;
        area_reg       <= area_next;
        hold_reg       <= hold_next;
        cand_reg       <= cand_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        dcnt_reg       <= dcnt_next;
        res_valid_reg  <= res_valid_next;
        res_reg        <= res_next;
        band_valid_reg <= band_valid_next;
        band_reg       <= band_next;
        fopen_reg      <= fopen_next;
    end

    assign out_valid  = out_valid_reg;
    assign band_valid = band_valid_reg;
    assign band_x     = band_reg.x;
    assign band_y     = band_reg.y;
    assign band_w     = band_reg.w;
    assign band_h     = band_reg.h;
    assign frame_open = fopen_reg;

    // Checks on the sequencer.
    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, cnt_reg <= CW'(MAX_RECTS))
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_reg != S_IDLE)
    `ASSERT_IMPLIES(a_band_open, clk, rst_n, out_valid_reg && band_valid_reg, fopen_reg)
    `ASSERT_IMPLIES(a_walk_bound, clk, rst_n, state_reg == S_B_FIN, walk_reg < cnt_reg)

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Damage rectangle tracker testbench
// Drives add, add-all, begin, next-band and end items through the valid/stall
// channel, predicts each band and frame flag with a model of the rectangle
// list, and compares every result field. The screen and strip registers are
// reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int NRECT = drt_pkg::MAX_RECTS_DEF;

    // One input item.
    typedef struct {
        logic [2:0]         act;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } item_t;

    // One band result.
    typedef struct {
        logic        bv;
        logic [11:0] bx;
        logic [11:0] by;
        logic [12:0] bw;
        logic [12:0] bh;
        logic        fo;
    } band_t;

    // Model rectangle at full precision.
    typedef struct {
        int x;
        int y;
        int w;
        int h;
    } box_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic        out_valid;
    logic        out_stall;
    logic        band_valid;
    logic [11:0] band_x;
    logic [11:0] band_y;
    logic [12:0] band_w;
    logic [12:0] band_h;
    logic        frame_open;

    damage_rect_tracker_band_slicer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .rect_x     (rect_x),
        .rect_y     (rect_y),
        .rect_w     (rect_w),
        .rect_h     (rect_h),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .band_valid (band_valid),
        .band_x     (band_x),
        .band_y     (band_y),
        .band_w     (band_w),
        .band_h     (band_h),
        .frame_open (frame_open)
    );

    // Model state of the rectangle list.
    box_t      lst[NRECT];
    int        lst_cnt;
    bit        lst_open;
    int        walk;
    int        rowoff;
    int        scr_w;
    int        scr_h;
    int        strip;

    item_t     pending_items[$];
    band_t     expected_bands[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_cycles;
    int        errors;
    int        bands_seen;
    int        items_sent;
    int        items_pushed;
    bit        in_taken;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit boxes_overlap(box_t a, box_t b);
        return a.x < b.x + b.w && b.x < a.x + a.w && a.y < b.y + b.h && b.y < a.y + a.h;
    endfunction

    function automatic box_t box_union(box_t a, box_t b);
        box_t u;
        int   x2;
        int   y2;
        x2 = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
        y2 = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
        u.x = (a.x < b.x) ? a.x : b.x;
        u.y = (a.y < b.y) ? a.y : b.y;
        u.w = x2 - u.x;
        u.h = y2 - u.y;
        return u;
    endfunction

    // Clip a rectangle and fold it into the list.
    function automatic void list_add(item_t it);
        box_t c;
        box_t u;
        int   x2;
        int   y2;
        int   best;
        int   best_cost;
        int   cost;
        best = 0;
        best_cost = 32'h7FFF_FFFF;
        if (it.w <= 0 || it.h <= 0)
            return;
        x2 = (it.x + it.w < scr_w) ? it.x + it.w : scr_w;
        y2 = (it.y + it.h < scr_h) ? it.y + it.h : scr_h;
        c.x = (it.x > 0) ? it.x : 0;
        c.y = (it.y > 0) ? it.y : 0;
        c.w = x2 - c.x;
        c.h = y2 - c.y;
        if (c.w <= 0 || c.h <= 0)
            return;
        for (int i = 0; i < lst_cnt; i++)
        begin
            if (boxes_overlap(lst[i], c))
            begin
                lst[i] = box_union(lst[i], c);
                return;
            end
        end
        if (lst_cnt < NRECT)
        begin
            lst[lst_cnt] = c;
            lst_cnt++;
            return;
        end
        for (int i = 0; i < NRECT; i++)
        begin
            u = box_union(lst[i], c);
            cost = u.w * u.h - lst[i].w * lst[i].h;
            if (cost < best_cost)
            begin
                best_cost = cost;
                best = i;
            end
        end
        lst[best] = box_union(lst[best], c);
    endfunction

    // Coalesce overlapping entries, restarting after every merge.
    function automatic void list_coalesce();
        bit again;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            for (int i = 0; i < lst_cnt && !again; i++)
                for (int j = i + 1; j < lst_cnt && !again; j++)
                    if (boxes_overlap(lst[i], lst[j]))
                    begin
                        lst[i] = box_union(lst[i], lst[j]);
                        lst_cnt--;
                        lst[j] = lst[lst_cnt];
                        again = 1'b1;
                    end
        end
    endfunction

    // Work out the result of one item and advance the model.
    function automatic band_t predict_band(item_t it);
        band_t b;
        box_t  r;
        int    rows;
        b = '{default: '0};
        case (it.act)
            drt_pkg::ACT_ADD:
                if (!lst_open)
                    list_add(it);
            drt_pkg::ACT_ALL:
                if (!lst_open)
                begin
                    lst[0] = '{0, 0, scr_w, scr_h};
                    lst_cnt = 1;
                end
            drt_pkg::ACT_BEGIN:
                if (!lst_open)
                begin
                    list_coalesce();
                    walk = 0;
                    rowoff = 0;
                    lst_open = 1'b1;
                end
            drt_pkg::ACT_NEXT:
                if (lst_open)
                begin
                    while (walk < lst_cnt && !b.bv)
                    begin
                        r = lst[walk];
                        if (rowoff >= r.h)
                        begin
                            walk++;
                            rowoff = 0;
                        end
                        else
                        begin
                            rows = (r.w > 0) ? strip / r.w : 1;
                            if (rows < 1)
                                rows = 1;
                            if (rows > r.h - rowoff)
                                rows = r.h - rowoff;
                            b.bv = 1'b1;
                            b.bx = r.x[11:0];
                            b.by = 12'(r.y + rowoff);
                            b.bw = r.w[12:0];
                            b.bh = rows[12:0];
                            rowoff += rows;
                        end
                    end
                end
            drt_pkg::ACT_END:
                if (lst_open)
                begin
                    lst_cnt = 0;
                    lst_open = 1'b0;
                end
            default:
                ;
        endcase
        b.fo = lst_open;
        return b;
    endfunction

    // Driver: offers the oldest pending item, changing inputs at the falling edge.
    // A new item is chosen only when nothing is offered or the last one was taken.
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            in_taken = 1'b0;
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                action   <= pending_items[0].act;
                rect_x   <= pending_items[0].x;
                rect_y   <= pending_items[0].y;
                rect_w   <= pending_items[0].w;
                rect_h   <= pending_items[0].h;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, or a long hold counted down cycle by cycle.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Acceptance: predict at the edge where an item is taken.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            expected_bands.push_back(predict_band(pending_items[0]));
            void'(pending_items.pop_front());
            items_sent++;
            in_taken = 1'b1;
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        band_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bands.size() == 0)
            begin
                $error("result with no expectation waiting");
                errors++;
            end
            else
            begin
                e = expected_bands.pop_front();
                if (e.bv) bands_seen++;
                if (band_valid !== e.bv)
                begin
                    $error("band_valid expected %0d got %0d", e.bv, band_valid);
                    errors++;
                end
                if (band_x !== e.bx)
                begin
                    $error("band_x expected %0d got %0d", e.bx, band_x);
                    errors++;
                end
                if (band_y !== e.by)
                begin
                    $error("band_y expected %0d got %0d", e.by, band_y);
                    errors++;
                end
                if (band_w !== e.bw)
                begin
                    $error("band_w expected %0d got %0d", e.bw, band_w);
                    errors++;
                end
                if (band_h !== e.bh)
                begin
                    $error("band_h expected %0d got %0d", e.bh, band_h);
                    errors++;
                end
                if (frame_open !== e.fo)
                begin
                    $error("frame_open expected %0d got %0d", e.fo, frame_open);
                    errors++;
                end
            end
        end
    end

    // Register write over the configuration port, a setup and an access phase, then a readback.
    task automatic write_reg(input drt_pkg::reg_idx_t idx, input int unsigned val);
        int unsigned mask;
        case (idx)
            drt_pkg::REG_WIDTH:  mask = 32'hFFF;
            drt_pkg::REG_HEIGHT: mask = 32'hFFF;
            default:             mask = 32'hFFFFF;
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(4 * idx);
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (pready !== 1'b1)
        begin
            $error("pready expected 1 got %0d", pready);
            errors++;
        end
        if (prdata !== (val & mask))
        begin
            $error("prdata expected %0d got %0d", val & mask, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            drt_pkg::REG_WIDTH:  scr_w = val & mask;
            drt_pkg::REG_HEIGHT: scr_h = val & mask;
            default:             strip = val & mask;
        endcase
    endtask

    task automatic push_item(input logic [2:0] a, input int x, input int y,
                             input int w, input int h);
        item_t it;
        it.act = a;
        it.x = 16'(x);
        it.y = 16'(y);
        it.w = 16'(w);
        it.h = 16'(h);
        pending_items.push_back(it);
        items_pushed++;
    endtask

    // Wait until all items are taken and every result has come back.
    task automatic drain();
        while (pending_items.size() > 0 || expected_bands.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Random rectangle: mostly on screen, sometimes far outside or empty.
    function automatic int rnd_coord(int span);
        case ($urandom_range(9))
            0:       return $signed(16'($urandom()));
            1:       return -$urandom_range(50);
            default: return $urandom_range(span);
        endcase
    endfunction

    // One frame: maybe an add-all, adds, a begin, a run of mostly next-band items, an end.
    task automatic push_frame();
        int n;
        n = $urandom_range(12);
        if ($urandom_range(9) == 0)
            push_item(drt_pkg::ACT_ALL, 0, 0, 0, 0);
        for (int i = 0; i < n; i++)
            push_item(drt_pkg::ACT_ADD, rnd_coord(scr_w), rnd_coord(scr_h),
                      ($urandom_range(7) == 0) ? rnd_coord(40) : $urandom_range(1, scr_w / 3 + 1),
                      ($urandom_range(7) == 0) ? rnd_coord(40) : $urandom_range(1, scr_h / 3 + 1));
        push_item(drt_pkg::ACT_BEGIN, 0, 0, 0, 0);
        for (int i = 0; i < $urandom_range(3, 14); i++)
            push_item(($urandom_range(15) == 0) ? 3'($urandom_range(7)) : drt_pkg::ACT_NEXT,
                      $urandom(), $urandom(), $urandom(), $urandom());
        push_item(drt_pkg::ACT_END, 0, 0, 0, 0);
    endtask

    task automatic run_random(input int count);
        int target;
        target = items_pushed + count;
        while (items_pushed < target)
        begin
            if ($urandom_range(4) == 0)
                push_item(3'($urandom_range(7)), $urandom(), $urandom(), $urandom(), $urandom());
            else
                push_frame();
            while (pending_items.size() > 20)
                @(posedge clk);
        end
        drain();
    endtask

    // Run limit.
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_taken = 1'b0;
        out_stall = 1'b0;
        action = '0;
        rect_x = '0;
        rect_y = '0;
        rect_w = '0;
        rect_h = '0;
        errors = 0;
        bands_seen = 0;
        items_sent = 0;
        items_pushed = 0;
        hold_cycles = 0;
        send_idle_pct = 13;
        recv_idle_pct = 47;
        lst_cnt = 0;
        lst_open = 1'b0;
        walk = 0;
        rowoff = 0;
        scr_w = drt_pkg::SCREEN_W_RST;
        scr_h = drt_pkg::SCREEN_H_RST;
        strip = drt_pkg::STRIP_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, every action, ignored and empty cases.
        push_item(drt_pkg::ACT_NEXT, 0, 0, 0, 0);
        push_item(drt_pkg::ACT_END, 0, 0, 0, 0);
        push_item(3'd5, 0, 0, 0, 0);
        push_item(3'd7, -1, -1, -1, -1);
        push_item(drt_pkg::ACT_ADD, 10, 10, 0, 5);
        push_item(drt_pkg::ACT_ADD, 10, 10, 5, -32768);
        push_item(drt_pkg::ACT_ADD, 32767, 32767, 32767, 32767);
        push_item(drt_pkg::ACT_ADD, -32768, -32768, 32767, 32767);
        push_item(drt_pkg::ACT_ADD, 0, 0, 20, 20);
        push_item(drt_pkg::ACT_ADD, 30, 30, 20, 20);
        push_item(drt_pkg::ACT_ADD, 15, 15, 20, 20);
        push_item(drt_pkg::ACT_BEGIN, 0, 0, 0, 0);
        push_item(drt_pkg::ACT_ADD, 100, 100, 5, 5);
        push_item(drt_pkg::ACT_BEGIN, 0, 0, 0, 0);
        for (int i = 0; i < 6; i++)
            push_item(drt_pkg::ACT_NEXT, 0, 0, 0, 0);
        push_item(drt_pkg::ACT_END, 0, 0, 0, 0);
        push_item(drt_pkg::ACT_ALL, 0, 0, 0, 0);
        push_item(drt_pkg::ACT_BEGIN, 0, 0, 0, 0);
        push_item(drt_pkg::ACT_NEXT, 0, 0, 0, 0);
        push_item(drt_pkg::ACT_END, 0, 0, 0, 0);
        drain();

        // Long receiver hold while items keep coming.
        hold_cycles = 300;
        run_random(40);

        run_random(150);
        write_reg(drt_pkg::REG_WIDTH, 4095);
        write_reg(drt_pkg::REG_HEIGHT, 4095);
        write_reg(drt_pkg::REG_STRIP, 32'hFFFFF);
        run_random(60);
        write_reg(drt_pkg::REG_WIDTH, 1);
        write_reg(drt_pkg::REG_HEIGHT, 1);
        write_reg(drt_pkg::REG_STRIP, 1);
        run_random(40);

        send_idle_pct = 47;
        recv_idle_pct = 13;
        write_reg(drt_pkg::REG_WIDTH, 64);
        write_reg(drt_pkg::REG_HEIGHT, 48);
        write_reg(drt_pkg::REG_STRIP, 100);
        run_random(120);
        write_reg(drt_pkg::REG_STRIP, 0);
        run_random(40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(drt_pkg::REG_WIDTH, 320);
        write_reg(drt_pkg::REG_HEIGHT, 200);
        write_reg(drt_pkg::REG_STRIP, 2000);
        run_random(120);

        $display("Covered %0d items, %0d bands, over several screen and strip settings.",
                 items_sent, bands_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
